@@ rtl/lpr_pkg.sv @@
package lpr_pkg;

    localparam int ROUTE_ENTRIES = 1024;
    localparam int GATE_COUNT    = 8192;

    localparam int ADDR_W  = 32;
    localparam int LEN_W   = 6;
    localparam int GATE_W  = 14;
    localparam int STAT_W  = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int IDX_W = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(ROUTE_ENTRIES + 1);

    localparam logic [LEN_W-1:0]  MAX_LEN      = LEN_W'(32);
    localparam logic [GATE_W-1:0] GATE_DISCARD = GATE_W'(GATE_COUNT);

    localparam logic [1:0] ACT_LOOKUP = 2'd0;
    localparam logic [1:0] ACT_ADD    = 2'd1;
    localparam logic [1:0] ACT_DELETE = 2'd2;
    localparam logic [1:0] ACT_CLEAR  = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
    localparam logic [STAT_W-1:0] ST_BAD_PREFIX = 3'd1;
    localparam logic [STAT_W-1:0] ST_BAD_GATE   = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL       = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_A = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_B = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_C = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_D = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GATE  = 3'd4;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_CLEAR,
        S_WRITE,
        S_RESP
    } t_state;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] prefix;
        logic [LEN_W-1:0]  len;
        logic [GATE_W-1:0] gate;
    } t_route;

    typedef struct packed {
        logic             en;
        logic             we;
        logic [IDX_W-1:0] addr;
        t_route           wdata;
    } t_mem_req;

    typedef struct packed {
        logic              hit;
        logic [GATE_W-1:0] gate;
    } t_special;

    // Network mask for a prefix length; lengths of 32 and above give all ones.
    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
        return ~({ADDR_W{1'b1}} >> len);
    endfunction

endpackage

@@ rtl/lpr_route_mem.sv @@
module lpr_route_mem (
    input  logic               i_clk,
    input  lpr_pkg::t_mem_req  i_req,
    output lpr_pkg::t_route    o_rdata
);

    lpr_pkg::t_route r_mem [lpr_pkg::ROUTE_ENTRIES];
    lpr_pkg::t_route r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            if (i_req.we) begin
                r_mem[i_req.addr] <= i_req.wdata;
            end else begin
                r_rdata <= r_mem[i_req.addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/lpr_cfg_regs.sv @@
module lpr_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [lpr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lpr_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [lpr_pkg::ADDR_W-1:0]       i_addr,
    output lpr_pkg::t_special                o_special
);

    logic [lpr_pkg::ADDR_W-1:0] r_key_a;
    logic [lpr_pkg::ADDR_W-1:0] r_key_b;
    logic [lpr_pkg::ADDR_W-1:0] r_key_c;
    logic [lpr_pkg::ADDR_W-1:0] r_key_d;
    logic [lpr_pkg::GATE_W-1:0] r_gate;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_a <= 32'h0a00_0000;
            r_key_b <= 32'h0a03_0000;
            r_key_c <= 32'h0a14_0000;
            r_key_d <= 32'h0a27_0000;
            r_gate  <= lpr_pkg::GATE_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                lpr_pkg::CFG_KEY_A: r_key_a <= i_cfg_data;
                lpr_pkg::CFG_KEY_B: r_key_b <= i_cfg_data;
                lpr_pkg::CFG_KEY_C: r_key_c <= i_cfg_data;
                lpr_pkg::CFG_KEY_D: r_key_d <= i_cfg_data;
                lpr_pkg::CFG_GATE:  r_gate  <= i_cfg_data[lpr_pkg::GATE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_special.hit  = (i_addr == r_key_a) || (i_addr == r_key_b) ||
                            (i_addr == r_key_c) || (i_addr == r_key_d);
    assign o_special.gate = r_gate;

endmodule

@@ rtl/lpr_ctrl.sv @@
module lpr_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [1:0]                     i_action,
    input  logic [lpr_pkg::ADDR_W-1:0]     i_address,
    input  logic [lpr_pkg::LEN_W-1:0]      i_prefix_length,
    input  logic [lpr_pkg::GATE_W-1:0]     i_gate_in,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [lpr_pkg::GATE_W-1:0]     o_gate_out,
    output logic [lpr_pkg::STAT_W-1:0]     o_status,
    output logic [lpr_pkg::ADDR_W-1:0]     o_addr,
    input  lpr_pkg::t_special              i_special,
    output lpr_pkg::t_mem_req              o_mem_req,
    input  lpr_pkg::t_route                i_mem_rdata
);

    lpr_pkg::t_state r_state, n_state;

    logic [lpr_pkg::CNT_W-1:0]  r_idx, n_idx;
    logic                       r_ev, n_ev;
    logic [lpr_pkg::IDX_W-1:0]  r_ev_idx, n_ev_idx;
    logic [lpr_pkg::IDX_W-1:0]  r_wr_idx, n_wr_idx;
    logic [lpr_pkg::IDX_W-1:0]  r_free_idx, n_free_idx;
    logic                       r_have_free, n_have_free;
    logic [lpr_pkg::LEN_W-1:0]  r_best_len, n_best_len;
    logic [lpr_pkg::GATE_W-1:0] r_best_gate, n_best_gate;
    logic [lpr_pkg::GATE_W-1:0] r_default, n_default;

    logic [1:0]                 r_action, n_action;
    logic [lpr_pkg::ADDR_W-1:0] r_addr, n_addr;
    logic [lpr_pkg::LEN_W-1:0]  r_len, n_len;
    logic [lpr_pkg::GATE_W-1:0] r_gate, n_gate;

    logic [lpr_pkg::GATE_W-1:0] r_res_gate, n_res_gate;
    logic [lpr_pkg::STAT_W-1:0] r_res_status, n_res_status;
    logic                       r_out_valid, n_out_valid;
    logic [lpr_pkg::GATE_W-1:0] r_out_gate, n_out_gate;
    logic [lpr_pkg::STAT_W-1:0] r_out_status, n_out_status;

    logic accept;
    logic len_bad;
    logic gate_bad;
    logic len_zero;
    logic ent_lpm;
    logic ent_same;
    logic ent_free;
    logic stop_found;
    logic scan_end;
    logic issue;
    logic sweep_last;
    logic out_load;

    assign accept     = (r_state == lpr_pkg::S_IDLE) && i_in_valid;
    assign len_bad    = (r_len > lpr_pkg::MAX_LEN) ||
                        ((r_addr & ~lpr_pkg::prefix_mask(r_len)) != '0);
    assign gate_bad   = {1'b0, r_gate} > (lpr_pkg::GATE_W + 1)'(lpr_pkg::GATE_COUNT);
    assign len_zero   = (r_len == '0);

    // Evaluation of the entry read in the previous cycle.
    assign ent_lpm    = r_ev && i_mem_rdata.valid && (i_mem_rdata.len > r_best_len) &&
                        ((r_addr & lpr_pkg::prefix_mask(i_mem_rdata.len)) ==
                         i_mem_rdata.prefix);
    assign ent_same   = r_ev && i_mem_rdata.valid && (i_mem_rdata.prefix == r_addr) &&
                        (i_mem_rdata.len == r_len);
    assign ent_free   = r_ev && !i_mem_rdata.valid && !r_have_free;
    assign stop_found = ent_same && (r_action != lpr_pkg::ACT_LOOKUP);
    assign scan_end   = (r_idx == lpr_pkg::CNT_W'(lpr_pkg::ROUTE_ENTRIES)) && !r_ev;
    assign issue      = (r_state == lpr_pkg::S_SCAN) && !stop_found &&
                        (r_idx != lpr_pkg::CNT_W'(lpr_pkg::ROUTE_ENTRIES));
    assign sweep_last = (r_idx == lpr_pkg::CNT_W'(lpr_pkg::ROUTE_ENTRIES - 1));
    assign out_load   = (r_state == lpr_pkg::S_RESP) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            lpr_pkg::S_INIT: begin
                if (sweep_last) n_state = lpr_pkg::S_IDLE;
            end
            lpr_pkg::S_IDLE: begin
                if (i_in_valid) n_state = lpr_pkg::S_DECODE;
            end
            lpr_pkg::S_DECODE: begin
                case (r_action)
                    lpr_pkg::ACT_LOOKUP: begin
                        n_state = i_special.hit ? lpr_pkg::S_RESP : lpr_pkg::S_SCAN;
                    end
                    lpr_pkg::ACT_ADD: begin
                        n_state = (len_bad || gate_bad || len_zero) ?
                                  lpr_pkg::S_RESP : lpr_pkg::S_SCAN;
                    end
                    lpr_pkg::ACT_DELETE: begin
                        n_state = (len_bad || len_zero) ? lpr_pkg::S_RESP : lpr_pkg::S_SCAN;
                    end
                    default: n_state = lpr_pkg::S_CLEAR;
                endcase
            end
            lpr_pkg::S_SCAN: begin
                if (stop_found) begin
                    n_state = lpr_pkg::S_WRITE;
                end else if (scan_end) begin
                    if (r_action == lpr_pkg::ACT_ADD && r_have_free) begin
                        n_state = lpr_pkg::S_WRITE;
                    end else begin
                        n_state = lpr_pkg::S_RESP;
                    end
                end
            end
            lpr_pkg::S_CLEAR: begin
                if (sweep_last) n_state = lpr_pkg::S_RESP;
            end
            lpr_pkg::S_WRITE: n_state = lpr_pkg::S_RESP;
            lpr_pkg::S_RESP: begin
                if (out_load) n_state = lpr_pkg::S_IDLE;
            end
            default: n_state = lpr_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_idx        = r_idx;
        n_ev         = issue;
        n_ev_idx     = r_idx[lpr_pkg::IDX_W-1:0];
        n_wr_idx     = r_wr_idx;
        n_free_idx   = r_free_idx;
        n_have_free  = r_have_free;
        n_best_len   = r_best_len;
        n_best_gate  = r_best_gate;
        n_default    = r_default;
        n_action     = r_action;
        n_addr       = r_addr;
        n_len        = r_len;
        n_gate       = r_gate;
        n_res_gate   = r_res_gate;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_gate   = r_out_gate;
        n_out_status = r_out_status;

        o_mem_req.en    = 1'b0;
        o_mem_req.we    = 1'b0;
        o_mem_req.addr  = r_idx[lpr_pkg::IDX_W-1:0];
        o_mem_req.wdata = '0;

        case (r_state)
            lpr_pkg::S_INIT, lpr_pkg::S_CLEAR: begin
                // Sweep that writes every entry as invalid.
                o_mem_req.en = 1'b1;
                o_mem_req.we = 1'b1;
                n_idx = sweep_last ? '0 : r_idx + 1'b1;
            end
            lpr_pkg::S_IDLE: begin
                if (accept) begin
                    n_action = i_action;
                    n_addr   = i_address;
                    n_len    = i_prefix_length;
                    n_gate   = i_gate_in;
                end
            end
            lpr_pkg::S_DECODE: begin
                n_idx        = '0;
                n_have_free  = 1'b0;
                n_best_len   = '0;
                n_best_gate  = r_default;
                n_res_gate   = '0;
                n_res_status = lpr_pkg::ST_OK;
                case (r_action)
                    lpr_pkg::ACT_LOOKUP: begin
                        if (i_special.hit) n_res_gate = i_special.gate;
                    end
                    lpr_pkg::ACT_ADD: begin
                        if (len_bad) begin
                            n_res_status = lpr_pkg::ST_BAD_PREFIX;
                        end else if (gate_bad) begin
                            n_res_status = lpr_pkg::ST_BAD_GATE;
                        end else if (len_zero) begin
                            n_default = r_gate;
                        end
                    end
                    lpr_pkg::ACT_DELETE: begin
                        if (len_bad) begin
                            n_res_status = lpr_pkg::ST_BAD_PREFIX;
                        end else if (len_zero) begin
                            n_default = lpr_pkg::GATE_DISCARD;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            lpr_pkg::S_SCAN: begin
                o_mem_req.en = issue;
                if (issue) n_idx = r_idx + 1'b1;
                if (ent_lpm) begin
                    n_best_len  = i_mem_rdata.len;
                    n_best_gate = i_mem_rdata.gate;
                end
                if (ent_free) begin
                    n_have_free = 1'b1;
                    n_free_idx  = r_ev_idx;
                end
                if (stop_found) begin
                    n_wr_idx = r_ev_idx;
                end else if (scan_end) begin
                    case (r_action)
                        lpr_pkg::ACT_LOOKUP: n_res_gate = r_best_gate;
                        lpr_pkg::ACT_ADD: begin
                            if (r_have_free) begin
                                n_wr_idx = r_free_idx;
                            end else begin
                                n_res_status = lpr_pkg::ST_FULL;
                            end
                        end
                        default: n_res_status = lpr_pkg::ST_NOT_FOUND;
                    endcase
                end
            end
            lpr_pkg::S_WRITE: begin
                // An add writes the whole entry; a delete clears its valid bit.
                o_mem_req.en           = 1'b1;
                o_mem_req.we           = 1'b1;
                o_mem_req.addr         = r_wr_idx;
                o_mem_req.wdata.valid  = (r_action == lpr_pkg::ACT_ADD);
                o_mem_req.wdata.prefix = r_addr;
                o_mem_req.wdata.len    = r_len;
                o_mem_req.wdata.gate   = r_gate;
            end
            lpr_pkg::S_RESP: begin
                if (out_load) begin
                    n_out_valid  = 1'b1;
                    n_out_gate   = r_res_gate;
                    n_out_status = r_res_status;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lpr_pkg::S_INIT;
            r_idx       <= '0;
            r_ev        <= 1'b0;
            r_have_free <= 1'b0;
            r_default   <= lpr_pkg::GATE_DISCARD;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_ev        <= n_ev;
            r_have_free <= n_have_free;
            r_default   <= n_default;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ev_idx     <= n_ev_idx;
        r_wr_idx     <= n_wr_idx;
        r_free_idx   <= n_free_idx;
        r_best_len   <= n_best_len;
        r_best_gate  <= n_best_gate;
        r_action     <= n_action;
        r_addr       <= n_addr;
        r_len        <= n_len;
        r_gate       <= n_gate;
        r_res_gate   <= n_res_gate;
        r_res_status <= n_res_status;
        r_out_gate   <= n_out_gate;
        r_out_status <= n_out_status;
    end

    assign o_in_ready  = (r_state == lpr_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_gate_out  = r_out_gate;
    assign o_status    = r_out_status;
    assign o_addr      = r_addr;

endmodule

@@ rtl/ipv4_longest_prefix_router.sv @@
// IPv4 route table with longest-prefix match, held in one single-port memory of
// ROUTE_ENTRIES entries that is walked one entry per cycle. A request is taken
// only while the block is idle; its result is registered, so the next request
// can be taken while that result waits. A lookup, add or delete walks the whole
// table through the memory port before its result is set, and an add that writes
// a new entry then writes it in a further state (an add or delete that finds its
// route stops early). A clear writes every entry before its result is set.
// A lookup of a special address, a rejected prefix or gate, and an add or delete
// of length zero have their result set straight from the decode state, with no
// walk. The next request is taken in the cycle after the result is loaded, later
// if the previous result still waits. After reset the memory is swept to empty
// and no request is taken meanwhile; configuration writes are taken at any time.
module ipv4_longest_prefix_router (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [lpr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lpr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [1:0]                     i_action,
    input  logic [lpr_pkg::ADDR_W-1:0]     i_address,
    input  logic [lpr_pkg::LEN_W-1:0]      i_prefix_length,
    input  logic [lpr_pkg::GATE_W-1:0]     i_gate_in,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [lpr_pkg::GATE_W-1:0]     o_gate_out,
    output logic [lpr_pkg::STAT_W-1:0]     o_status
);

    lpr_pkg::t_special          special;
    lpr_pkg::t_mem_req          mem_req;
    lpr_pkg::t_route            mem_rdata;
    logic [lpr_pkg::ADDR_W-1:0] cur_addr;

    lpr_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_addr      (cur_addr),
        .o_special   (special)
    );

    lpr_route_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    lpr_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_action        (i_action),
        .i_address       (i_address),
        .i_prefix_length (i_prefix_length),
        .i_gate_in       (i_gate_in),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_gate_out      (o_gate_out),
        .o_status        (o_status),
        .o_addr          (cur_addr),
        .i_special       (special),
        .o_mem_req       (mem_req),
        .i_mem_rdata     (mem_rdata)
    );

endmodule

@@ test/tb_ipv4_longest_prefix_router.sv @@
`timescale 1ns / 1ps

module tb_ipv4_longest_prefix_router;
    import lpr_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED   = 3'd7;
    localparam logic [ADDR_W-1:0]    RESET_KEY_A  = 32'h0A00_0000;
    localparam logic [ADDR_W-1:0]    RESET_KEY_B  = 32'h0A03_0000;
    localparam logic [ADDR_W-1:0]    RESET_KEY_C  = 32'h0A14_0000;
    localparam logic [ADDR_W-1:0]    RESET_KEY_D  = 32'h0A27_0000;
    localparam logic [GATE_W-1:0]    GATE_ALL     = {GATE_W{1'b1}};
    localparam int                   TAIL_CYCLES  = ROUTE_ENTRIES + 64;
    localparam int                   REUSE_ROUTES = 48;

    typedef struct packed {
        logic [GATE_W-1:0] gate;
        logic [STAT_W-1:0] status;
    } t_route_result;

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data      = '0;
    logic                  i_in_valid      = 1'b0;
    logic                  o_in_ready;
    logic [1:0]            i_action        = ACT_LOOKUP;
    logic [ADDR_W-1:0]     i_address       = '0;
    logic [LEN_W-1:0]      i_prefix_length = '0;
    logic [GATE_W-1:0]     i_gate_in       = '0;
    logic                  o_out_valid;
    logic                  i_out_ready     = 1'b0;
    logic [GATE_W-1:0]     o_gate_out;
    logic [STAT_W-1:0]     o_status;

    // Mirror of the route table and the special-address settings.
    logic              route_valid  [ROUTE_ENTRIES];
    logic [ADDR_W-1:0] route_prefix [ROUTE_ENTRIES];
    logic [LEN_W-1:0]  route_len    [ROUTE_ENTRIES];
    logic [GATE_W-1:0] route_gate   [ROUTE_ENTRIES];
    logic [GATE_W-1:0] fallback_gate;
    logic [ADDR_W-1:0] special_key  [4];
    logic [GATE_W-1:0] special_gate;

    t_route_result pending_results[$];
    t_route_result head_result;
    int            error_count   = 0;
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;

    ipv4_longest_prefix_router dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_action        (i_action),
        .i_address       (i_address),
        .i_prefix_length (i_prefix_length),
        .i_gate_in       (i_gate_in),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_gate_out      (o_gate_out),
        .o_status        (o_status)
    );

    always #4 i_clk = ~i_clk;

    function automatic logic [ADDR_W-1:0] addr_mask(input logic [LEN_W-1:0] len);
        logic [63:0] wide;
        wide = 64'hFFFF_FFFF_0000_0000 >> len;
        return wide[31:0];
    endfunction

    function automatic void reset_route_model();
        for (int k = 0; k < ROUTE_ENTRIES; k++) begin
            route_valid[k]  = 1'b0;
            route_prefix[k] = '0;
            route_len[k]    = '0;
            route_gate[k]   = '0;
        end
        fallback_gate  = GATE_DISCARD;
        special_key[0] = RESET_KEY_A;
        special_key[1] = RESET_KEY_B;
        special_key[2] = RESET_KEY_C;
        special_key[3] = RESET_KEY_D;
        special_gate   = GATE_W'(1);
    endfunction

    // Applies one request to the mirrored table and returns the response it must produce.
    function automatic t_route_result route_table_apply(input logic [1:0]        act,
                                                        input logic [ADDR_W-1:0] addr,
                                                        input logic [LEN_W-1:0]  len,
                                                        input logic [GATE_W-1:0] gate);
        t_route_result     res;
        logic [LEN_W-1:0]  best_len;
        logic              is_special;
        int                free_idx;
        int                hit_idx;
        int                k;
        res.gate   = '0;
        res.status = ST_OK;
        best_len   = '0;
        is_special = 1'b0;
        free_idx   = -1;
        hit_idx    = -1;
        case (act)
            ACT_LOOKUP: begin
                res.gate = fallback_gate;
                for (k = 0; k < 4; k++)
                    if (addr == special_key[k])
                        is_special = 1'b1;
                if (is_special) begin
                    res.gate = special_gate;
                end else begin
                    // Table lengths are never zero, so a strict compare picks the longest.
                    for (k = 0; k < ROUTE_ENTRIES; k++)
                        if (route_valid[k] && (addr & addr_mask(route_len[k])) == route_prefix[k]
                                && route_len[k] > best_len) begin
                            best_len = route_len[k];
                            res.gate = route_gate[k];
                        end
                end
            end
            ACT_ADD, ACT_DELETE: begin
                if (len > MAX_LEN || (addr & ~addr_mask(len)) != '0) begin
                    res.status = ST_BAD_PREFIX;
                end else if (act == ACT_ADD && gate > GATE_DISCARD) begin
                    res.status = ST_BAD_GATE;
                end else if (len == '0) begin
                    fallback_gate = (act == ACT_ADD) ? gate : GATE_DISCARD;
                end else begin
                    for (k = 0; k < ROUTE_ENTRIES; k++) begin
                        if (route_valid[k]) begin
                            if (hit_idx < 0 && route_prefix[k] == addr && route_len[k] == len)
                                hit_idx = k;
                        end else if (free_idx < 0) begin
                            free_idx = k;
                        end
                    end
                    if (act == ACT_DELETE) begin
                        if (hit_idx >= 0)
                            route_valid[hit_idx] = 1'b0;
                        else
                            res.status = ST_NOT_FOUND;
                    end else if (hit_idx >= 0) begin
                        route_gate[hit_idx] = gate;
                    end else if (free_idx < 0) begin
                        res.status = ST_FULL;
                    end else begin
                        route_valid[free_idx]  = 1'b1;
                        route_prefix[free_idx] = addr;
                        route_len[free_idx]    = len;
                        route_gate[free_idx]   = gate;
                    end
                end
            end
            default: begin
                for (k = 0; k < ROUTE_ENTRIES; k++)
                    route_valid[k] = 1'b0;
            end
        endcase
        return res;
    endfunction

    // Valid is left high after acceptance; the next call either replaces the
    // payload or lowers it, so it never toggles twice within one step.
    task automatic send_request(input logic [1:0]        act,
                                input logic [ADDR_W-1:0] addr,
                                input logic [LEN_W-1:0]  len,
                                input logic [GATE_W-1:0] gate);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_action        <= act;
        i_address       <= addr;
        i_prefix_length <= len;
        i_gate_in       <= gate;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        pending_results.push_back(route_table_apply(act, addr, len, gate));
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (pending_results.size() != 0);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    task automatic load_settings(input logic [ADDR_W-1:0] key_a,
                                 input logic [ADDR_W-1:0] key_b,
                                 input logic [ADDR_W-1:0] key_c,
                                 input logic [ADDR_W-1:0] key_d,
                                 input logic [GATE_W-1:0] gate);
        wait_drained();
        cfg_write(CFG_KEY_A, key_a);
        cfg_write(CFG_KEY_B, key_b);
        cfg_write(CFG_KEY_C, key_c);
        cfg_write(CFG_KEY_D, key_d);
        cfg_write(CFG_GATE, CFG_DATA_W'(gate));
        // An unmapped index must leave every register alone.
        cfg_write(CFG_UNUSED, $urandom);
        i_cfg_we       <= 1'b0;
        special_key[0] = key_a;
        special_key[1] = key_b;
        special_key[2] = key_c;
        special_key[3] = key_d;
        special_gate   = gate;
    endtask

    task automatic test_directed_basics();
        logic [31:0] noise;
        noise = $urandom;
        for (int k = 0; k < 4; k++)
            send_request(ACT_LOOKUP, special_key[k], 6'd63, GATE_ALL);
        send_request(ACT_LOOKUP, 32'h0000_0000, '0, '0);
        send_request(ACT_LOOKUP, 32'hFFFF_FFFF, '0, '0);
        send_request(ACT_ADD, 32'h0000_0000, 6'd0, GATE_W'(GATE_COUNT - 1));
        send_request(ACT_ADD, 32'h0A00_0000, 6'd8, 14'd5);
        send_request(ACT_ADD, 32'h0A01_0000, 6'd16, 14'd6);
        send_request(ACT_ADD, 32'hFFFF_FFFF, 6'd32, GATE_DISCARD);
        send_request(ACT_LOOKUP, 32'h0A01_0203, '0, '0);
        send_request(ACT_LOOKUP, 32'h0A02_0000, '0, '0);
        send_request(ACT_LOOKUP, 32'hFFFF_FFFF, '0, '0);
        send_request(ACT_LOOKUP, 32'hFFFF_FFFE, '0, '0);
        send_request(ACT_ADD, 32'h0A00_0000, 6'd8, 14'd7);
        send_request(ACT_ADD, 32'h0B00_0000, 6'd33, 14'd3);
        send_request(ACT_ADD, 32'h0B00_0000, 6'd63, 14'd3);
        send_request(ACT_ADD, 32'h0A00_0001, 6'd8, 14'd3);
        send_request(ACT_ADD, 32'h0B00_0000, 6'd8, GATE_W'(GATE_COUNT + 1));
        // Both the prefix and the gate are bad; the prefix error wins.
        send_request(ACT_ADD, 32'h0B00_0000, 6'd40, GATE_ALL);
        send_request(ACT_DELETE, 32'h0A01_0000, 6'd16, GATE_ALL);
        send_request(ACT_DELETE, 32'h0A01_0000, 6'd16, '0);
        send_request(ACT_DELETE, 32'h0A01_8000, 6'd16, '0);
        send_request(ACT_DELETE, 32'h0000_0000, 6'd0, '0);
        send_request(ACT_LOOKUP, 32'h0C00_0000, '0, '0);
        send_request(ACT_CLEAR, noise, noise[5:0], noise[31:18]);
        send_request(ACT_LOOKUP, 32'h0A01_0203, '0, '0);
    endtask

    task automatic test_special_registers();
        load_settings(32'h0000_0000, 32'hFFFF_FFFF, 32'h0A01_0203, 32'h0A02_0000, '0);
        send_request(ACT_ADD, 32'h0A00_0000, 6'd8, 14'd9);
        for (int pass = 0; pass < 2; pass++) begin
            for (int k = 0; k < 4; k++)
                send_request(ACT_LOOKUP, special_key[k], '0, '0);
            send_request(ACT_LOOKUP, RESET_KEY_A, '0, '0);
            send_request(ACT_LOOKUP, 32'h0000_0001, '0, '0);
            if (pass == 0)
                load_settings(32'h0000_0000, 32'hFFFF_FFFF, 32'h0A01_0203, 32'h0A02_0000,
                              GATE_DISCARD);
        end
    endtask

    // Fills the low part of the table, then checks overwrites, deletes and the
    // reuse of freed entries.
    task automatic test_table_reuse();
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  len;
        wait_drained();
        send_request(ACT_CLEAR, '0, '0, '0);
        for (int k = 0; k < REUSE_ROUTES; k++) begin
            addr = ADDR_W'(k) << (ADDR_W - IDX_W);
            len  = LEN_W'($urandom_range(32, IDX_W));
            send_request(ACT_ADD, addr, len, GATE_W'($urandom_range(GATE_COUNT)));
        end
        send_request(ACT_ADD, 32'h0000_0001, 6'd32, 14'd11);
        send_request(ACT_ADD, route_prefix[5], route_len[5], 14'd12);
        send_request(ACT_DELETE, route_prefix[REUSE_ROUTES - 3], route_len[REUSE_ROUTES - 3],
                     '0);
        send_request(ACT_DELETE, route_prefix[3], route_len[3], '0);
        send_request(ACT_ADD, 32'h0000_0001, 6'd32, 14'd11);
        send_request(ACT_ADD, 32'h0000_0002, 6'd32, 14'd13);
        send_request(ACT_ADD, 32'h0000_0003, 6'd32, 14'd14);
        send_request(ACT_LOOKUP, 32'h0000_0001, '0, '0);
        send_request(ACT_LOOKUP, 32'h0000_0002, '0, '0);
        for (int k = 0; k < 4; k++)
            send_request(ACT_LOOKUP, $urandom, '0, '0);
        send_request(ACT_CLEAR, '0, '0, '0);
        send_request(ACT_LOOKUP, 32'h0000_0001, '0, '0);
    endtask

    // Routes are built around a few drifting base addresses so that prefixes nest
    // and lookups hit several of them at once.
    task automatic test_random_traffic(input int count);
        logic [ADDR_W-1:0] traffic_base [4];
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  len;
        logic [GATE_W-1:0] gate;
        logic [31:0]       noise;
        int                pick;
        int                slot;
        for (int k = 0; k < 4; k++)
            traffic_base[k] = $urandom;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(31) == 0)
                traffic_base[$urandom_range(3)] = $urandom;
            base  = traffic_base[$urandom_range(3)];
            len   = LEN_W'($urandom_range(32, 1));
            gate  = ($urandom_range(15) == 0) ? GATE_DISCARD :
                    GATE_W'($urandom_range(GATE_COUNT - 1));
            noise = $urandom;
            addr  = base & addr_mask(len);
            pick  = $urandom_range(199);
            if (pick < 84) begin
                case ($urandom_range(9))
                    0:       addr = special_key[$urandom_range(3)];
                    1:       addr = $urandom;
                    default: addr = addr | (noise & ~addr_mask(len));
                endcase
                send_request(ACT_LOOKUP, addr, noise[31:26], noise[13:0]);
            end else if (pick < 197) begin
                if (pick >= 144 && $urandom_range(9) < 6) begin
                    slot = $urandom_range(63);
                    if (route_valid[slot]) begin
                        addr = route_prefix[slot];
                        len  = route_len[slot];
                    end
                end
                case ($urandom_range(19))
                    0: len = LEN_W'($urandom_range(63, 33));
                    1: begin
                        len  = LEN_W'($urandom_range(31));
                        addr = (base & addr_mask(len)) | (32'h1 << $urandom_range(31 - len));
                    end
                    2: gate = GATE_W'($urandom_range(GATE_ALL, GATE_COUNT + 1));
                    3: begin
                        len  = '0;
                        addr = '0;
                    end
                    default: ;
                endcase
                send_request((pick < 144) ? ACT_ADD : ACT_DELETE, addr, len, gate);
            end else begin
                send_request(ACT_CLEAR, noise, noise[5:0], noise[31:18]);
            end
            if ($urandom_range(49) == 0)
                wait_drained();
        end
    endtask

    always @(posedge i_clk)
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: gate_out %0d, status %0d", o_gate_out, o_status);
                error_count++;
            end else begin
                head_result = pending_results.pop_front();
                if (o_gate_out !== head_result.gate) begin
                    $error("gate_out: expected %0d, actual %0d", head_result.gate, o_gate_out);
                    error_count++;
                end
                if (o_status !== head_result.status) begin
                    $error("status: expected %0d, actual %0d", head_result.status, o_status);
                    error_count++;
                end
            end
        end
    end

    initial begin
        reset_route_model();
        repeat (4) @(posedge i_clk);
        i_rst_n       <= 1'b1;
        send_idle_pct = 12;
        recv_idle_pct = 74;
        test_directed_basics();
        test_special_registers();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_table_reuse();

        load_settings($urandom, $urandom, $urandom, $urandom,
                      GATE_W'($urandom_range(GATE_COUNT)));
        send_idle_pct = 12;
        recv_idle_pct = 74;
        test_random_traffic(160);

        load_settings(32'hFFFF_FFFF, 32'h0000_0000, $urandom, $urandom, GATE_DISCARD);
        send_idle_pct = 74;
        recv_idle_pct = 12;
        test_random_traffic(160);

        load_settings(RESET_KEY_A, RESET_KEY_B, RESET_KEY_C, RESET_KEY_D, GATE_W'(1));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(160);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #80_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/lpr_pkg.sv
rtl/lpr_route_mem.sv
rtl/lpr_cfg_regs.sv
rtl/lpr_ctrl.sv
rtl/ipv4_longest_prefix_router.sv
test/tb_ipv4_longest_prefix_router.sv
